>>> hdl/lfrb_pkg.sv
// Package for the length-prefixed frame ring buffer.
// Holds the payload structs, controller states and the control/status types
// shared by the controller, the datapath and the top level.
`default_nettype none

package lfrb_pkg;

  // Default store depth in bytes
  localparam int unsigned DepthDefault = 64;
  // A frame spans its length field value plus this many bytes
  localparam int unsigned LenOffset    = 2;

  // Action codes of an input item
  localparam logic ActPush = 1'b0;
  localparam logic ActPop  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       length_error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_EMIT
  } lfrb_state_e;

  // Which pointer-relative address the store read port uses
  typedef enum logic [1:0] {
    RD_CUR,
    RD_NEXT1,
    RD_NEXT2
  } rd_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    push_wr;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    latch_hi;
    logic    load_frame;
    logic    emit_byte;
    logic    emit_err;
  } lfrb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_frame;
    logic too_long;
  } lfrb_status_t;

endpackage

`default_nettype wire

>>> hdl/lfrb_ctrl.sv
// Controller of the length-prefixed frame ring buffer.
// Sequences pushes, length reads and byte pops; depends on lfrb_pkg.
`default_nettype none

module lfrb_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  input  wire                   action_i,
  input  lfrb_pkg::lfrb_status_t status_i,
  output logic                  busy,
  output lfrb_pkg::lfrb_cmd_t   cmd_o
);
  import lfrb_pkg::*;

  lfrb_state_e state_q, state_d;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{push_wr: 1'b0, rd_en: 1'b0, rd_sel: RD_CUR, latch_hi: 1'b0,
                load_frame: 1'b0, emit_byte: 1'b0, emit_err: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ActPush) begin
            cmd_o.push_wr = 1'b1;
          end else if (status_i.in_frame) begin
            // Frame already open: fetch the next byte directly
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_CUR;
            state_d      = ST_EMIT;
          end else begin
            // New frame: fetch the length high byte first
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_NEXT1;
            state_d      = ST_LEN_HI;
          end
        end
      end
      ST_LEN_HI: begin
        cmd_o.latch_hi = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_NEXT2;
        state_d        = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        if (status_i.too_long) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.load_frame = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel     = RD_CUR;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_byte = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/lfrb_dp.sv
// Datapath of the length-prefixed frame ring buffer.
// Byte store with valid bits, pointers, frame byte count and result register;
// depends on lfrb_pkg.
`default_nettype none

module lfrb_dp #(
  parameter int unsigned DEPTH = lfrb_pkg::DepthDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  [7:0]             byte_in_i,
  input  lfrb_pkg::lfrb_cmd_t    cmd_i,
  output lfrb_pkg::lfrb_status_t status_o,
  output logic                   result_valid_o,
  output lfrb_pkg::out_item_t    result_o
);
  import lfrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [16:0] DepthW  = 17'(DEPTH);
  localparam logic [16:0] OffsetW = 17'(LenOffset);

  // Advance a pointer by one, wrapping at the store depth
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  logic [7:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW-1:0]   rp1, rp2, rd_addr;
  logic [7:0]      rd_data_q;
  logic            rd_vld_q;
  logic [7:0]      rd_byte;
  logic [7:0]      hi_q;
  logic [16:0]     total;
  logic [CW-1:0]   count_q;
  logic            in_frame_q;
  logic            last;
  logic            res_valid_q;
  out_item_t       res_q;

  assign rp1 = wrap_inc(rp_q);
  assign rp2 = wrap_inc(rp1);

  // Select the read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_CUR:   rd_addr = rp_q;
      RD_NEXT1: rd_addr = rp1;
      RD_NEXT2: rd_addr = rp2;
      default:  rd_addr = rp_q;
    endcase
  end

  // Write pushed bytes, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      mem[wp_q] <= byte_in_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // An entry never written or already consumed reads as zero
  assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;

  // Track valid entries and the write and read pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
    end else begin
      if (cmd_i.push_wr) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= wrap_inc(wp_q);
      end
      if (cmd_i.emit_byte) begin
        vld_q[rp_q] <= 1'b0;
        rp_q        <= rp1;
      end
    end
  end

  // Hold the length high byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_hi) begin
      hi_q <= rd_byte;
    end
  end

  assign total = {1'b0, hi_q, rd_byte} + OffsetW;
  assign last  = (count_q == CW'(1));

  // Count the bytes left in the open frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      in_frame_q <= 1'b0;
    end else if (cmd_i.load_frame) begin
      count_q    <= total[CW-1:0];
      in_frame_q <= 1'b1;
    end else if (cmd_i.emit_byte) begin
      count_q <= count_q - CW'(1);
      if (last) begin
        in_frame_q <= 1'b0;
      end
    end
  end

  // Register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_byte | cmd_i.emit_err;
    end
  end

  // Register the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      res_q <= '{out_byte: 8'h00, last_byte: 1'b1, length_error: 1'b1};
    end else if (cmd_i.emit_byte) begin
      res_q <= '{out_byte: rd_byte, last_byte: last, length_error: 1'b0};
    end
  end

  assign status_o.in_frame = in_frame_q;
  assign status_o.too_long = (total > DepthW);
  assign result_valid_o    = res_valid_q;
  assign result_o          = res_q;

endmodule

`default_nettype wire

>>> hdl/length_prefixed_frame_ring_buffer.sv
// Ring buffer of length-prefixed frames, a push of one byte or a pop of one
// frame byte per transfer. A push is taken while busy stays low, so pushes can
// stream every cycle while no pop holds busy high. A pop inside an open frame
// holds busy high through the emit state; the first pop of a frame also passes
// through the length-high and length-low states, as the single registered read
// port of the store fetches the two length bytes and then the frame byte one
// after the other (on a too large length an error result is given and the emit
// state is skipped). Each result appears on result_o with result_valid_o high
// for one cycle, in the same cycle as busy falls; the receiver cannot stall and
// must take it then. The store reads as zero after reset and needs no clearing
// pass. Nothing guards against overrun or reading an empty store.
// Depends on lfrb_pkg, lfrb_ctrl and lfrb_dp.
`default_nettype none

module length_prefixed_frame_ring_buffer #(
  parameter int unsigned DEPTH = lfrb_pkg::DepthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  input  lfrb_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                result_valid_o,
  output lfrb_pkg::out_item_t result_o
);
  import lfrb_pkg::*;

  lfrb_cmd_t    cmd;
  lfrb_status_t status;

  lfrb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (item_i.action),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  lfrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_in_i      (item_i.byte_in),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // A result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding pop");

  // A push never leaves the block busy and never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.action == ActPush) |=> (!busy && !result_valid_o))
    else $error("push made the block busy or produced a result");

  // An error result is a lone zero byte marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.length_error) |->
      (result_o.last_byte && result_o.out_byte == 8'h00))
    else $error("malformed length error result");

endmodule

`default_nettype wire
